// ===== design/jsmd_pkg.sv =====
// ----------------------------------------------------------------------------
// jsmd_pkg
// shared types and constants of the job-shop makespan decoder
// ----------------------------------------------------------------------------
package jsmd_pkg;

  // default sizing
  localparam int MAX_JOBS_DEF      = 32;
  localparam int MAX_MACHINES_DEF  = 32;
  localparam int DURATION_BITS_DEF = 17;
  localparam int TIME_BITS_DEF     = 32;

  // fixed field widths of the stream payload
  localparam int JOB_ID_W   = 5;
  localparam int STEP_W_IN  = 5;
  localparam int MACH_ID_W  = 5;
  localparam int DUR_W_IN   = 17;
  localparam int CFG_W      = 6;
  localparam int MAKESPAN_W = 32;
  localparam int CMP_W      = 9;

  // command carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GENE = 1'b1;

  // register indexes
  localparam logic REG_JOB_COUNT  = 1'b0;
  localparam logic REG_MACH_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JOB,
    ST_ROUTE,
    ST_MACH,
    ST_ADD,
    ST_FIN
  } state_t;

endpackage

// ===== design/job_shop_makespan_decoder_core.sv =====
// ----------------------------------------------------------------------------
// job_shop_makespan_decoder_core
// evaluates an operation-based job-shop chromosome into a semi-active
// schedule and returns its makespan and an invalid flag
// ----------------------------------------------------------------------------
// A route load (tuser = 0) is taken in the idle state and, if its job and
// step are in range, written straight into the route memory. A gene
// (tuser = 1) walks a chain of three registered memory reads (job state,
// route entry, machine state), a start time compare, a saturating add with
// write-back and a final state that folds the finish time into the running
// maximum; a gene rejected on its job number, step count or route machine
// goes from that read to the final state. The gene marked tlast produces one
// result and then clears the evaluation state at once (per-entry valid bits,
// no clearing pass); if an earlier result is still waiting, the block holds
// in its final state until that transfer completes. Route entries are not
// cleared by reset and must be loaded before any gene uses them.
module job_shop_makespan_decoder_core
  import jsmd_pkg::*;
#(
  parameter int MAX_JOBS      = MAX_JOBS_DEF,
  parameter int MAX_MACHINES  = MAX_MACHINES_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // job_id[4:0], step_index[9:5], machine_id[14:10],
                                  // duration[31:15]
  input  logic        in_tuser,   // command
  input  logic        in_tlast,   // last_gene
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // makespan[31:0]
  output logic        out_tuser   // invalid
);

  localparam int JW     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int MW     = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int SW     = $clog2(MAX_MACHINES + 1);
  localparam int RDEPTH = MAX_JOBS * MAX_MACHINES;
  localparam int RW     = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int RTE_W  = MACH_ID_W + DURATION_BITS;
  localparam int JE_W   = SW + TIME_BITS;
  localparam int SUM_W  = ((TIME_BITS > DURATION_BITS) ? TIME_BITS : DURATION_BITS) + 1;

  localparam logic [CMP_W-1:0] MAX_J_C = CMP_W'(MAX_JOBS);
  localparam logic [CMP_W-1:0] MAX_M_C = CMP_W'(MAX_MACHINES);
  localparam logic [RW-1:0]    ROW_C   = RW'(MAX_MACHINES);

  // payload fields
  logic [JOB_ID_W-1:0]      in_job;
  logic [STEP_W_IN-1:0]     in_step;
  logic [MACH_ID_W-1:0]     in_mach;
  logic [DUR_W_IN-1:0]      in_dur;

  assign in_job  = in_tdata[4:0];
  assign in_step = in_tdata[9:5];
  assign in_mach = in_tdata[14:10];
  assign in_dur  = in_tdata[31:15];

  // control state
  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         job_count_r;
  logic [CFG_W-1:0]         mach_count_r;
  logic [MAX_JOBS-1:0]      job_vld_r;
  logic [MAX_MACHINES-1:0]  mach_vld_r;
  logic [TIME_BITS-1:0]     max_r;
  logic                     bad_r;
  logic                     upd_r;
  logic                     out_tvalid_r;

  // per-gene payload
  logic [JW-1:0]            job_r;
  logic                     job_ok_r;
  logic                     last_r;
  logic [SW-1:0]            step_r;
  logic [TIME_BITS-1:0]     jfree_r;
  logic [MW-1:0]            mach_r;
  logic [DURATION_BITS-1:0] dur_r;
  logic [TIME_BITS-1:0]     start_r;
  logic [TIME_BITS-1:0]     finish_r;
  logic [31:0]              out_tdata_r;
  logic                     out_tuser_r;

  // memories
  logic [RTE_W-1:0]         route_mem [RDEPTH];
  logic [JE_W-1:0]          job_mem   [MAX_JOBS];
  logic [TIME_BITS-1:0]     mach_mem  [MAX_MACHINES];
  logic [RTE_W-1:0]         route_rd_r;
  logic [JE_W-1:0]          job_rd_r;
  logic [TIME_BITS-1:0]     mach_rd_r;

  // datapath signals
  logic                     in_acc;
  logic                     load_ok;
  logic                     route_we;
  logic [RW-1:0]            route_waddr;
  logic [RW-1:0]            route_raddr;
  logic [JW-1:0]            job_raddr;
  logic [MW-1:0]            mach_raddr;
  logic                     wb_en;
  logic [SW-1:0]            step_cur;
  logic [TIME_BITS-1:0]     jfree_cur;
  logic                     step_ok;
  logic [MACH_ID_W-1:0]     route_mach;
  logic                     mach_ok;
  logic [TIME_BITS-1:0]     mfree_cur;
  logic [SUM_W-1:0]         sum;
  logic [TIME_BITS-1:0]     finish;
  logic [TIME_BITS-1:0]     max_new;
  logic                     emit_go;
  logic                     bad_set;

  assign in_acc    = in_tvalid & in_tready;
  assign load_ok   = (CMP_W'(in_job) < MAX_J_C) && (CMP_W'(in_step) < MAX_M_C);

  assign step_cur  = job_vld_r[job_r] ? job_rd_r[JE_W-1 -: SW] : '0;
  assign jfree_cur = job_vld_r[job_r] ? job_rd_r[TIME_BITS-1:0] : '0;
  assign step_ok   = job_ok_r && (CMP_W'(step_cur) < CMP_W'(mach_count_r)) &&
                     (CMP_W'(step_cur) < MAX_M_C);

  assign route_mach = route_rd_r[RTE_W-1 -: MACH_ID_W];
  assign mach_ok    = CMP_W'(route_mach) < MAX_M_C;

  assign mfree_cur  = mach_vld_r[mach_r] ? mach_rd_r : '0;

  // saturating finish time
  assign sum    = SUM_W'(start_r) + SUM_W'(dur_r);
  assign finish = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

  assign max_new = (upd_r && (finish_r > max_r)) ? finish_r : max_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == CMD_GENE)) begin
          state_nxt = ST_JOB;
        end
      end
      ST_JOB: begin
        state_nxt = step_ok ? ST_ROUTE : ST_FIN;
      end
      ST_ROUTE: begin
        state_nxt = mach_ok ? ST_MACH : ST_FIN;
      end
      ST_MACH: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!last_r || emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_tready   = 1'b0;
    route_we    = 1'b0;
    wb_en       = 1'b0;
    emit_go     = 1'b0;
    bad_set     = 1'b0;
    job_raddr   = JW'(in_job);
    route_waddr = RW'(in_job) * ROW_C + RW'(in_step);
    route_raddr = RW'(job_r) * ROW_C + RW'(step_cur);
    mach_raddr  = MW'(route_mach);
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        route_we  = in_acc && (in_tuser == CMD_LOAD) && load_ok;
      end
      ST_JOB: begin
        bad_set = !step_ok;
      end
      ST_ROUTE: begin
        bad_set = !mach_ok;
      end
      ST_ADD: begin
        wb_en = 1'b1;
      end
      ST_FIN: begin
        emit_go = last_r && (!out_tvalid_r || out_tready);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // memories: registered read
  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem[route_waddr] <= {in_mach, DURATION_BITS'(in_dur)};
    end
    route_rd_r <= route_mem[route_raddr];
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      job_mem[job_r] <= {step_r + SW'(1), finish};
    end
    job_rd_r <= job_mem[job_raddr];
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      mach_mem[mach_r] <= finish;
    end
    mach_rd_r <= mach_mem[mach_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      job_count_r  <= CFG_W'(1);
      mach_count_r <= CFG_W'(1);
      job_vld_r    <= '0;
      mach_vld_r   <= '0;
      max_r        <= '0;
      bad_r        <= 1'b0;
      upd_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_JOB_COUNT:  job_count_r  <= cfg_wdata;
          REG_MACH_COUNT: mach_count_r <= cfg_wdata;
          default: begin
            job_count_r <= job_count_r;
          end
        endcase
      end
      if (emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (in_acc) begin
        upd_r <= 1'b0;
      end
      if (bad_set) begin
        bad_r <= 1'b1;
      end
      if (wb_en) begin
        job_vld_r[job_r]   <= 1'b1;
        mach_vld_r[mach_r] <= 1'b1;
        upd_r              <= 1'b1;
      end
      if (state_r == ST_FIN) begin
        max_r <= emit_go ? '0 : max_new;
        upd_r <= 1'b0;
      end
      // result leaves, evaluation state starts over
      if (emit_go) begin
        job_vld_r    <= '0;
        mach_vld_r   <= '0;
        bad_r        <= 1'b0;
      end
    end
  end

  // per-gene payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_r    <= JW'(in_job);
      job_ok_r <= (CMP_W'(in_job) < CMP_W'(job_count_r)) && (CMP_W'(in_job) < MAX_J_C);
      last_r   <= in_tlast;
    end
    if (state_r == ST_JOB) begin
      step_r  <= step_cur;
      jfree_r <= jfree_cur;
    end
    if (state_r == ST_ROUTE) begin
      mach_r <= MW'(route_mach);
      dur_r  <= route_rd_r[DURATION_BITS-1:0];
    end
    if (state_r == ST_MACH) begin
      start_r <= (mfree_cur > jfree_r) ? mfree_cur : jfree_r;
    end
    if (wb_en) begin
      finish_r <= finish;
    end
    if (emit_go) begin
      out_tdata_r <= MAKESPAN_W'(max_new);
      out_tuser_r <= bad_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
